// File: src/bdi_pkg.sv
// Shared types and constants for the block direction interlock.
// Holds command, direction and status codes, the table entry layout and reset values.
// No dependencies.
package bdi_pkg;

  localparam int MAX_SECTIONS_DEF = 64;

  localparam int CMD_W    = 4;
  localparam int SECT_W   = 6;
  localparam int AXLE_W   = 8;
  localparam int TICK_W   = 32;
  localparam int USE_W    = 7;
  localparam int DELAY_W  = 16;
  localparam int CFG_IX_W = 1;
  localparam int CFG_DW   = 16;

  localparam logic [USE_W-1:0]   SECTIONS_IN_USE_RST   = 7'd64;
  localparam logic [DELAY_W-1:0] RESET_DELAY_TICKS_RST = 16'd600;

  localparam logic [CFG_IX_W-1:0] CFG_SECTIONS_IN_USE   = 1'b0;
  localparam logic [CFG_IX_W-1:0] CFG_RESET_DELAY_TICKS = 1'b1;

  typedef enum logic [3:0] {
    CMD_BLW  = 4'd0,
    CMD_BLP  = 4'd1,
    CMD_BLO  = 4'd2,
    CMD_BLZ  = 4'd3,
    CMD_BLAI = 4'd4,
    CMD_BLA  = 4'd5,
    CMD_OPS  = 4'd6,
    CMD_SLI  = 4'd7,
    CMD_SLK  = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    DIR_NEUTRAL    = 3'd0,
    DIR_OUT_PEND   = 3'd1,
    DIR_IN_PEND    = 3'd2,
    DIR_OUT        = 3'd3,
    DIR_IN         = 3'd4,
    DIR_EMERGENCY  = 3'd5,
    DIR_RESET_PEND = 3'd6
  } dir_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOTFND = 2'd1,
    ST_INVAL  = 2'd2,
    ST_SAFETY = 2'd3
  } status_e;

  typedef struct packed {
    dir_e              dir;
    logic              open;
    logic              tick_valid;
    logic [TICK_W-1:0] tick;
  } entry_t;

  localparam entry_t ENTRY_RST = '{dir: DIR_NEUTRAL, open: 1'b0, tick_valid: 1'b0, tick: '0};

endpackage

// File: src/block_direction_interlock.sv
// Top level of the block direction interlock: handshakes, configuration and sequencing.
// Instantiates bdi_table and bdi_eval; uses bdi_pkg.
//
// Usage: an operator command item enters on the input channel (command, section index,
// axle count, tick) under valid and ready. Each item yields exactly one result item
// (status, direction, open flag, neighbour confirmation) on the output channel.
// The per-section state lives in one table memory with a registered read.
// An item is read from the table on the edge at which it is accepted, then evaluated
// and written back on the edge that also loads its result into the output register,
// once that register is free. A new item is accepted only after the previous one has
// been evaluated and written back; the read-modify-write of one table entry sets this.
// If the receiver stalls with a result still held, the next item is accepted and then
// waits in its evaluate step until the output register is free.
// After reset the table is swept to neutral, closed entries, one per cycle, and input
// ready stays low until after the sweep is done. Configuration writes are taken at any
// time, including during the sweep, and must only be issued while the block is idle.
module block_direction_interlock import bdi_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IX_W-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [SECT_W-1:0]   section_index_i,
  input  logic [AXLE_W-1:0]   axle_count_i,
  input  logic [TICK_W-1:0]   now_tick_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [2:0]          direction_now_o,
  output logic                block_open_o,
  output logic                needs_neighbor_confirm_o
);

  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int LW = ($clog2(MAX_SECTIONS + 1) > USE_W) ? $clog2(MAX_SECTIONS + 1) : USE_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e               state_q;
  logic [USE_W-1:0]     sections_in_use_q;
  logic [DELAY_W-1:0]   reset_delay_ticks_q;

  logic [CMD_W-1:0]     command_q;
  logic [AXLE_W-1:0]    axle_count_q;
  logic [TICK_W-1:0]    now_tick_q;
  logic [AW-1:0]        addr_q;
  logic                 not_found_q;

  logic                 out_valid_q;
  logic [1:0]           status_q;
  logic [2:0]           direction_q;
  logic                 open_q;
  logic                 confirm_q;

  logic                 accept;
  logic                 out_free;
  logic                 do_exec;
  logic [LW-1:0]        limit;
  logic                 not_found;
  logic [AW-1:0]        addr;
  logic                 clear_done;
  entry_t               cur_entry;
  entry_t               nxt_entry;
  status_e              eval_status;
  logic                 eval_confirm;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign do_exec    = (state_q == S_EXEC) && out_free;

  // Sections in use saturates at the table depth.
  always_comb begin
    if (LW'(sections_in_use_q) > LW'(MAX_SECTIONS)) begin
      limit = LW'(MAX_SECTIONS);
    end else begin
      limit = LW'(sections_in_use_q);
    end
  end

  assign not_found = (LW'(section_index_i) >= limit);
  assign addr      = AW'(section_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sections_in_use_q   <= SECTIONS_IN_USE_RST;
      reset_delay_ticks_q <= RESET_DELAY_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SECTIONS_IN_USE:   sections_in_use_q   <= cfg_wdata_i[USE_W-1:0];
        CFG_RESET_DELAY_TICKS: reset_delay_ticks_q <= cfg_wdata_i[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      command_q    <= command_i;
      axle_count_q <= axle_count_i;
      now_tick_q   <= now_tick_i;
      addr_q       <= addr;
      not_found_q  <= not_found;
    end
  end

  bdi_table #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .AW           (AW)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_addr_i    (addr),
    .rd_data_o    (cur_entry),
    .wr_en_i      (do_exec && !not_found_q && (eval_status == ST_OK)),
    .wr_addr_i    (addr_q),
    .wr_data_i    (nxt_entry),
    .clear_done_o (clear_done)
  );

  bdi_eval u_eval (
    .command_i           (command_q),
    .axle_count_i        (axle_count_q),
    .now_tick_i          (now_tick_q),
    .reset_delay_ticks_i (reset_delay_ticks_q),
    .cur_i               (cur_entry),
    .status_o            (eval_status),
    .nxt_o               (nxt_entry),
    .confirm_o           (eval_confirm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      direction_q <= DIR_NEUTRAL;
      open_q      <= 1'b0;
      confirm_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !do_exec) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (clear_done) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (not_found_q) begin
              status_q    <= ST_NOTFND;
              direction_q <= DIR_NEUTRAL;
              open_q      <= 1'b0;
              confirm_q   <= 1'b0;
            end else begin
              status_q    <= eval_status;
              direction_q <= nxt_entry.dir;
              open_q      <= nxt_entry.open;
              confirm_q   <= eval_confirm;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o              = out_valid_q;
  assign status_o                 = status_q;
  assign direction_now_o          = direction_q;
  assign block_open_o             = open_q;
  assign needs_neighbor_confirm_o = confirm_q;

endmodule

// File: src/bdi_table.sv
// Section table memory: one synchronous entry store with a registered read port.
// After reset a sweep writes the reset entry to every address. Uses bdi_pkg.
module bdi_table import bdi_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF,
  parameter int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output entry_t        rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  output logic          clear_done_o
);

  entry_t        mem [MAX_SECTIONS];
  entry_t        rd_data_q;
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  always_comb begin
    if (clearing_q) begin
      we = 1'b1;
      wa = clr_addr_q;
      wd = ENTRY_RST;
    end else begin
      we = wr_en_i;
      wa = wr_addr_i;
      wd = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == AW'(MAX_SECTIONS - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign clear_done_o = !clearing_q;

endmodule

// File: src/bdi_eval.sv
// Command rules: checks one command against the stored entry of its section.
// Produces the status, the entry to write back and the confirmation flag. Uses bdi_pkg.
module bdi_eval import bdi_pkg::*; (
  input  logic [CMD_W-1:0]   command_i,
  input  logic [AXLE_W-1:0]  axle_count_i,
  input  logic [TICK_W-1:0]  now_tick_i,
  input  logic [DELAY_W-1:0] reset_delay_ticks_i,
  input  entry_t             cur_i,
  output status_e            status_o,
  output entry_t             nxt_o,
  output logic               confirm_o
);

  logic [TICK_W:0] due_tick;
  logic            delay_met;

  // The deadline is kept one bit wider so that it never wraps.
  assign due_tick  = {1'b0, cur_i.tick} + {{(TICK_W + 1 - DELAY_W){1'b0}}, reset_delay_ticks_i};
  assign delay_met = ({1'b0, now_tick_i} >= due_tick);

  always_comb begin
    status_o  = ST_OK;
    nxt_o     = cur_i;
    confirm_o = 1'b0;
    case (cmd_e'(command_i))
      CMD_BLW: begin
        if (cur_i.dir != DIR_NEUTRAL) begin
          status_o = ST_INVAL;
        end else begin
          nxt_o.dir = DIR_OUT_PEND;
          confirm_o = 1'b1;
        end
      end
      CMD_BLP: begin
        if (cur_i.dir == DIR_OUT_PEND) begin
          nxt_o.dir  = DIR_OUT;
          nxt_o.open = 1'b1;
        end else if (cur_i.dir == DIR_IN_PEND) begin
          nxt_o.dir  = DIR_IN;
          nxt_o.open = 1'b1;
        end else begin
          status_o = ST_INVAL;
        end
      end
      CMD_BLO: begin
        if (cur_i.dir != DIR_OUT_PEND) begin
          status_o = ST_INVAL;
        end else begin
          nxt_o.dir = DIR_NEUTRAL;
        end
      end
      CMD_BLZ: begin
        if (cur_i.dir != DIR_OUT && cur_i.dir != DIR_IN) begin
          status_o = ST_INVAL;
        end else if (axle_count_i != '0) begin
          status_o = ST_SAFETY;
        end else begin
          nxt_o.dir  = DIR_NEUTRAL;
          nxt_o.open = 1'b0;
        end
      end
      CMD_BLAI: begin
        if (cur_i.dir == DIR_RESET_PEND) begin
          status_o = ST_INVAL;
        end else begin
          nxt_o.dir = DIR_EMERGENCY;
        end
      end
      CMD_BLA: begin
        if (cur_i.dir != DIR_EMERGENCY) begin
          status_o = ST_INVAL;
        end else begin
          nxt_o.dir  = DIR_NEUTRAL;
          nxt_o.open = 1'b0;
        end
      end
      CMD_OPS: begin
        if (cur_i.dir != DIR_EMERGENCY && cur_i.dir != DIR_RESET_PEND) begin
          status_o = ST_INVAL;
        end else begin
          nxt_o.dir  = DIR_NEUTRAL;
          nxt_o.open = 1'b0;
        end
      end
      CMD_SLI: begin
        if (cur_i.dir != DIR_NEUTRAL) begin
          status_o = ST_INVAL;
        end else begin
          nxt_o.dir        = DIR_RESET_PEND;
          nxt_o.tick       = now_tick_i;
          nxt_o.tick_valid = 1'b1;
        end
      end
      CMD_SLK: begin
        if (cur_i.dir != DIR_RESET_PEND) begin
          status_o = ST_INVAL;
        end else if (!cur_i.tick_valid || !delay_met) begin
          status_o = ST_SAFETY;
        end else begin
          nxt_o.dir  = DIR_NEUTRAL;
          nxt_o.open = 1'b0;
        end
      end
      default: begin
        status_o = ST_INVAL;
      end
    endcase
    // A rejected command reports and keeps the entry as it was.
    if (status_o != ST_OK) begin
      nxt_o     = cur_i;
      confirm_o = 1'b0;
    end
  end

endmodule

// File: tb/tb_block_direction_interlock.sv
// Self-checking testbench for the block direction interlock: directed command walks, then
// random operator commands under varied back-pressure, checked against a table-based predictor.
// Depends on bdi_pkg and block_direction_interlock.
module tb_block_direction_interlock;
  import bdi_pkg::*;

  localparam int                 CLK_PERIOD     = 12;
  localparam int                 TIMEOUT_CYCLES = 400000;
  localparam int                 SETTLE_CYCLES  = 4;
  localparam int                 REPLY_AW       = 4;
  localparam int                 REPLY_DEPTH    = 16;
  localparam logic [CMD_W-1:0]   CMD_CODE_MAX   = 4'hF;
  localparam logic [TICK_W-1:0]  TICK_MAX       = 32'hFFFF_FFFF;

  typedef struct packed {
    status_e status;
    dir_e    dir;
    logic    open;
    logic    confirm;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_IX_W-1:0] cfg_index_i;
  logic [CFG_DW-1:0]   cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i;
  logic [SECT_W-1:0]   section_index_i;
  logic [AXLE_W-1:0]   axle_count_i;
  logic [TICK_W-1:0]   now_tick_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [1:0]          status_o;
  logic [2:0]          direction_now_o;
  logic                block_open_o;
  logic                needs_neighbor_confirm_o;

  // Predicted section table and register copies.
  dir_e               sect_dir  [MAX_SECTIONS_DEF];
  logic               sect_open [MAX_SECTIONS_DEF];
  logic [TICK_W-1:0]  sli_tick  [MAX_SECTIONS_DEF];
  logic               sli_seen  [MAX_SECTIONS_DEF];
  logic [USE_W-1:0]   in_use_cfg;
  logic [DELAY_W-1:0] delay_cfg;

  // Replies still owed by the block, oldest at the read pointer.
  reply_t              reply_store [REPLY_DEPTH];
  logic [REPLY_AW-1:0] reply_wr = '0;
  logic [REPLY_AW-1:0] reply_rd = '0;
  int                  mismatches = 0;
  int                  send_gap_pct = 0;
  int                  recv_stall_pct = 0;
  logic [TICK_W-1:0]   cur_tick = '0;

  block_direction_interlock u_top (
    .clk_i                    (clk),
    .rst_ni                   (rst_ni),
    .cfg_we_i                 (cfg_we_i),
    .cfg_index_i              (cfg_index_i),
    .cfg_wdata_i              (cfg_wdata_i),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .command_i                (command_i),
    .section_index_i          (section_index_i),
    .axle_count_i             (axle_count_i),
    .now_tick_i               (now_tick_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .status_o                 (status_o),
    .direction_now_o          (direction_now_o),
    .block_open_o             (block_open_o),
    .needs_neighbor_confirm_o (needs_neighbor_confirm_o)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Applies one command to the predicted table and returns the reply it should produce.
  function automatic reply_t apply_command(logic [CMD_W-1:0] cmd, logic [SECT_W-1:0] idx,
                                           logic [AXLE_W-1:0] axles, logic [TICK_W-1:0] tick);
    int unsigned     limit;
    longint unsigned due;
    dir_e            nd;
    logic            no;
    reply_t          r;
    limit = (in_use_cfg > MAX_SECTIONS_DEF) ? MAX_SECTIONS_DEF : in_use_cfg;
    if (idx >= limit) begin
      r = '{ST_NOTFND, DIR_NEUTRAL, 1'b0, 1'b0};
      return r;
    end
    nd = sect_dir[idx];
    no = sect_open[idx];
    r  = '{ST_OK, sect_dir[idx], sect_open[idx], 1'b0};
    case (cmd)
      CMD_BLW: begin
        if (sect_dir[idx] != DIR_NEUTRAL) r.status = ST_INVAL;
        else begin
          nd = DIR_OUT_PEND;
          r.confirm = 1'b1;
        end
      end
      CMD_BLP: begin
        if (sect_dir[idx] == DIR_OUT_PEND) begin
          nd = DIR_OUT;
          no = 1'b1;
        end else if (sect_dir[idx] == DIR_IN_PEND) begin
          nd = DIR_IN;
          no = 1'b1;
        end else r.status = ST_INVAL;
      end
      CMD_BLO: begin
        if (sect_dir[idx] != DIR_OUT_PEND) r.status = ST_INVAL;
        else nd = DIR_NEUTRAL;
      end
      CMD_BLZ: begin
        if (sect_dir[idx] != DIR_OUT && sect_dir[idx] != DIR_IN) r.status = ST_INVAL;
        else if (axles != '0) r.status = ST_SAFETY;
        else begin
          nd = DIR_NEUTRAL;
          no = 1'b0;
        end
      end
      CMD_BLAI: begin
        if (sect_dir[idx] == DIR_RESET_PEND) r.status = ST_INVAL;
        else nd = DIR_EMERGENCY;
      end
      CMD_BLA: begin
        if (sect_dir[idx] != DIR_EMERGENCY) r.status = ST_INVAL;
        else begin
          nd = DIR_NEUTRAL;
          no = 1'b0;
        end
      end
      CMD_OPS: begin
        if (sect_dir[idx] != DIR_EMERGENCY && sect_dir[idx] != DIR_RESET_PEND)
          r.status = ST_INVAL;
        else begin
          nd = DIR_NEUTRAL;
          no = 1'b0;
        end
      end
      CMD_SLI: begin
        if (sect_dir[idx] != DIR_NEUTRAL) r.status = ST_INVAL;
        else begin
          nd = DIR_RESET_PEND;
          sli_tick[idx] = tick;
          sli_seen[idx] = 1'b1;
        end
      end
      CMD_SLK: begin
        // The deadline is formed in 64 bits, so a late request never wraps past zero.
        due = sli_tick[idx];
        due = due + delay_cfg;
        if (sect_dir[idx] != DIR_RESET_PEND) r.status = ST_INVAL;
        else if (!sli_seen[idx] || tick < due) r.status = ST_SAFETY;
        else begin
          nd = DIR_NEUTRAL;
          no = 1'b0;
        end
      end
      default: r.status = ST_INVAL;
    endcase
    if (r.status == ST_OK) begin
      sect_dir[idx]  = nd;
      sect_open[idx] = no;
      r.dir  = nd;
      r.open = no;
    end
    return r;
  endfunction

  // Picks a command that the section's present direction accepts, to drive deep sequences.
  function automatic logic [CMD_W-1:0] pick_command(dir_e d);
    int unsigned roll;
    roll = $urandom_range(99);
    case (d)
      DIR_NEUTRAL:    return (roll < 45) ? CMD_BLW : (roll < 85) ? CMD_SLI : CMD_BLAI;
      DIR_OUT_PEND:   return (roll < 60) ? CMD_BLP : (roll < 85) ? CMD_BLO : CMD_BLAI;
      DIR_IN_PEND:    return (roll < 80) ? CMD_BLP : CMD_BLAI;
      DIR_OUT,
      DIR_IN:         return (roll < 85) ? CMD_BLZ : CMD_BLAI;
      DIR_EMERGENCY:  return (roll < 55) ? CMD_BLA : CMD_OPS;
      DIR_RESET_PEND: return (roll < 80) ? CMD_SLK : CMD_OPS;
      default:        return CMD_BLAI;
    endcase
  endfunction

  task automatic advance_tick(int unsigned amount);
    longint unsigned sum;
    sum = cur_tick;
    sum = sum + amount;
    cur_tick = (sum > TICK_MAX) ? TICK_MAX : sum[TICK_W-1:0];
  endtask

  task automatic store_reply(reply_t r);
    reply_store[reply_wr] = r;
    reply_wr = reply_wr + 1'b1;
  endtask

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [SECT_W-1:0] idx,
                              logic [AXLE_W-1:0] axles, logic [TICK_W-1:0] tick);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    section_index_i <= idx;
    axle_count_i    <= axles;
    now_tick_i      <= tick;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    store_reply(apply_command(cmd, idx, axles, tick));
  endtask

  // Brings the block to rest: no item offered and every reply collected.
  task automatic settle();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (reply_wr != reply_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(logic [CFG_IX_W-1:0] index, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    if (index == CFG_SECTIONS_IN_USE) in_use_cfg = data[USE_W-1:0];
    else delay_cfg = data[DELAY_W-1:0];
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_direction_walk();
    send_command(CMD_BLW, 6'd0, 8'd0, cur_tick);
    send_command(CMD_BLW, 6'd0, 8'd0, cur_tick);
    send_command(CMD_BLP, 6'd0, 8'd0, cur_tick);
    advance_tick(3);
    send_command(CMD_BLZ, 6'd0, 8'd255, cur_tick);
    send_command(CMD_BLZ, 6'd0, 8'd0, cur_tick);
    send_command(CMD_BLW, 6'd0, 8'd17, cur_tick);
    send_command(CMD_BLO, 6'd0, 8'd0, cur_tick);
    send_command(CMD_BLAI, 6'd0, 8'd0, cur_tick);
    send_command(CMD_BLA, 6'd0, 8'd0, cur_tick);
    send_command(CMD_BLAI, 6'd0, 8'd0, cur_tick);
    send_command(CMD_OPS, 6'd0, 8'd0, cur_tick);
    send_command(CMD_CODE_MAX, 6'd0, 8'd0, cur_tick);
  endtask

  task automatic test_axle_reset_delay();
    logic [TICK_W-1:0] t0;
    advance_tick(10);
    t0 = cur_tick;
    send_command(CMD_SLI, 6'd63, 8'd0, cur_tick);
    cur_tick = t0 + RESET_DELAY_TICKS_RST - 1;
    send_command(CMD_SLK, 6'd63, 8'd0, cur_tick);
    cur_tick = t0 + RESET_DELAY_TICKS_RST;
    send_command(CMD_SLK, 6'd63, 8'd0, cur_tick);
    send_command(CMD_SLI, 6'd63, 8'd0, cur_tick);
    send_command(CMD_BLAI, 6'd63, 8'd0, cur_tick);
    send_command(CMD_OPS, 6'd63, 8'd0, cur_tick);
  endtask

  task automatic test_section_limits();
    settle();
    set_register(CFG_SECTIONS_IN_USE, 16'd0);
    send_command(CMD_BLW, 6'd0, 8'd0, cur_tick);
    settle();
    set_register(CFG_SECTIONS_IN_USE, 16'd1);
    send_command(CMD_BLAI, 6'd1, 8'd0, cur_tick);
    send_command(CMD_BLAI, 6'd0, 8'd0, cur_tick);
    settle();
    // Values above the table size saturate, so every index is present.
    set_register(CFG_SECTIONS_IN_USE, 16'd127);
    send_command(CMD_OPS, 6'd63, 8'd0, cur_tick);
    settle();
    set_register(CFG_SECTIONS_IN_USE, 16'(SECTIONS_IN_USE_RST));
  endtask

  task automatic test_random_commands(int count, int gap_pct, int stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      logic [SECT_W-1:0] idx;
      logic [CMD_W-1:0]  cmd;
      logic [AXLE_W-1:0] axles;
      int unsigned       roll;
      longint unsigned   target;
      idx   = ($urandom_range(99) < 70) ? SECT_W'($urandom_range(7))
                                        : SECT_W'($urandom_range(63));
      cmd   = ($urandom_range(99) < 75) ? pick_command(sect_dir[idx])
                                        : CMD_W'($urandom_range(CMD_CODE_MAX));
      axles = ($urandom_range(99) < 60) ? '0 : AXLE_W'($urandom_range(255));
      roll  = $urandom_range(99);
      if (roll < 60) advance_tick($urandom_range(20));
      else if (roll < 90) advance_tick($urandom_range(1000));
      else advance_tick($urandom_range(70000));
      // Half of the SLK requests after an SLI may move the tick onto or next to the deadline.
      if (cmd == CMD_SLK && sli_seen[idx] && $urandom_range(1) == 1) begin
        target = sli_tick[idx];
        target = target + delay_cfg + $urandom_range(2);
        if (target > 0) target = target - 1;
        if (target > cur_tick && target <= TICK_MAX) cur_tick = target[TICK_W-1:0];
      end
      send_command(cmd, idx, axles, cur_tick);
    end
  endtask

  task automatic test_tick_extremes();
    settle();
    set_register(CFG_RESET_DELAY_TICKS, 16'hFFFF);
    cur_tick = 32'hFFFF_0000;
    send_command(CMD_SLI, 6'd5, 8'd0, cur_tick);
    cur_tick = 32'hFFFF_FFFE;
    send_command(CMD_SLK, 6'd5, 8'd0, cur_tick);
    cur_tick = TICK_MAX;
    send_command(CMD_SLK, 6'd5, 8'd0, cur_tick);
    send_command(CMD_SLI, 6'd5, 8'd0, cur_tick);
    send_command(CMD_SLK, 6'd5, 8'd0, cur_tick);
    settle();
    set_register(CFG_RESET_DELAY_TICKS, 16'd0);
    send_command(CMD_SLK, 6'd5, 8'd0, cur_tick);
    test_random_commands(40, 0, 0);
  endtask

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_wr == reply_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected reply: status %0d dir %0d", status_o,
                                       direction_now_o);
      end else begin
        reply_t want;
        want = reply_store[reply_rd];
        reply_rd = reply_rd + 1'b1;
        if (status_o !== want.status || direction_now_o !== want.dir ||
            block_open_o !== want.open || needs_neighbor_confirm_o !== want.confirm) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp st %0d dir %0d open %0b conf %0b, got %0d %0d %0b %0b",
                     want.status, want.dir, want.open, want.confirm,
                     status_o, direction_now_o, block_open_o, needs_neighbor_confirm_o);
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    command_i       = '0;
    section_index_i = '0;
    axle_count_i    = '0;
    now_tick_i      = '0;
    in_use_cfg      = SECTIONS_IN_USE_RST;
    delay_cfg       = RESET_DELAY_TICKS_RST;
    for (int s = 0; s < MAX_SECTIONS_DEF; s++) begin
      sect_dir[s]  = DIR_NEUTRAL;
      sect_open[s] = 1'b0;
      sli_tick[s]  = '0;
      sli_seen[s]  = 1'b0;
    end
    send_gap_pct   = 6;
    recv_stall_pct = 52;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    test_direction_walk();
    test_axle_reset_delay();
    test_section_limits();

    test_random_commands(600, 6, 52);
    settle();
    set_register(CFG_SECTIONS_IN_USE, 16'($urandom_range(1, 63)));
    set_register(CFG_RESET_DELAY_TICKS, 16'($urandom_range(3000)));
    test_random_commands(600, 52, 6);
    settle();
    set_register(CFG_SECTIONS_IN_USE, 16'd100);
    set_register(CFG_RESET_DELAY_TICKS, 16'd1200);
    test_random_commands(600, 0, 0);

    test_tick_extremes();
    settle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
src/bdi_pkg.sv
src/bdi_table.sv
src/bdi_eval.sv
src/block_direction_interlock.sv
tb/tb_block_direction_interlock.sv
